// File: hw/rtl/scp_pkg.sv
// types and constants shared by the section container parser
package scp_pkg;

    typedef enum logic [2:0] {
        PH_MAGIC   = 3'd0,
        PH_VERSION = 3'd1,
        PH_COUNT   = 3'd2,
        PH_NLEN    = 3'd3,
        PH_NAME    = 3'd4,
        PH_DLEN    = 3'd5,
        PH_DATA    = 3'd6,
        PH_IDLE    = 3'd7
    } phase_t;

    typedef enum logic [2:0] {
        ROLE_HEADER  = 3'd0,
        ROLE_NLEN    = 3'd1,
        ROLE_NAME    = 3'd2,
        ROLE_DLEN    = 3'd3,
        ROLE_DATA    = 3'd4,
        ROLE_IGNORED = 3'd5
    } role_t;

    typedef enum logic [1:0] {
        ST_BUSY     = 2'd0,
        ST_DONE     = 2'd1,
        ST_REJECTED = 2'd2
    } status_t;

    typedef struct packed {
        phase_t      phase;
        logic [1:0]  field_pos;
        logic [31:0] field_acc;
        logic [31:0] sections_left;
        logic [31:0] current_section;
        logic [31:0] payload_left;
        status_t     parse_status;
    } scp_state_t;

    typedef struct packed {
        logic [7:0]  byte_echo;
        role_t       role;
        logic [31:0] section_index;
        logic        field_end;
        status_t     status;
    } scp_result_t;

    localparam logic [31:0] MAGIC_RESET   = 32'h4B42_324B;
    localparam logic [31:0] VERSION_RESET = 32'd1;

    localparam logic CFG_IDX_MAGIC   = 1'b0;
    localparam logic CFG_IDX_VERSION = 1'b1;

    localparam scp_state_t STATE_RESET = '{
        phase:           PH_MAGIC,
        field_pos:       2'd0,
        field_acc:       32'd0,
        sections_left:   32'd0,
        current_section: 32'd0,
        payload_left:    32'd0,
        parse_status:    ST_BUSY
    };

endpackage

// File: hw/rtl/scp_step.sv
// per-byte parse step: next state and tagged result from current state
module scp_step (
    input  scp_pkg::scp_state_t  cur_state,
    input  logic [7:0]           byte_value,
    input  logic                 end_of_buffer,
    input  logic [31:0]          magic_word,
    input  logic [31:0]          expected_version,
    output scp_pkg::scp_state_t  nxt_state,
    output scp_pkg::scp_result_t result
);

    logic [1:0]  pos;
    logic [31:0] acc_new;
    logic [31:0] payload_dec;
    logic [31:0] left_dec;
    logic [31:0] sec_inc;

    assign pos         = cur_state.field_pos;
    assign acc_new     = cur_state.field_acc | ({24'd0, byte_value} << {pos, 3'b000});
    assign payload_dec = cur_state.payload_left - 32'd1;
    assign left_dec    = cur_state.sections_left - 32'd1;
    assign sec_inc     = cur_state.current_section + 32'd1;

    always_comb begin
        scp_pkg::scp_state_t st;
        st = cur_state;
        result.byte_echo     = byte_value;
        result.role          = scp_pkg::ROLE_IGNORED;
        result.section_index = 32'd0;
        result.field_end     = 1'b0;
        result.status        = scp_pkg::ST_BUSY;

        case (cur_state.phase)
            scp_pkg::PH_MAGIC, scp_pkg::PH_VERSION, scp_pkg::PH_COUNT: begin
                result.role = scp_pkg::ROLE_HEADER;
                if (pos == 2'd3) begin
                    result.field_end = 1'b1;
                    st.field_pos = 2'd0;
                    st.field_acc = 32'd0;
                    if (cur_state.phase == scp_pkg::PH_MAGIC) begin
                        if (acc_new != magic_word) begin
                            st.parse_status = scp_pkg::ST_REJECTED;
                            st.phase        = scp_pkg::PH_IDLE;
                        end else begin
                            st.phase = scp_pkg::PH_VERSION;
                        end
                    end else if (cur_state.phase == scp_pkg::PH_VERSION) begin
                        if (acc_new != expected_version) begin
                            st.parse_status = scp_pkg::ST_REJECTED;
                            st.phase        = scp_pkg::PH_IDLE;
                        end else begin
                            st.phase = scp_pkg::PH_COUNT;
                        end
                    end else begin
                        st.sections_left   = acc_new;
                        st.current_section = 32'd0;
                        if (acc_new == 32'd0) begin
                            st.parse_status = scp_pkg::ST_DONE;
                            st.phase        = scp_pkg::PH_IDLE;
                        end else begin
                            st.phase = scp_pkg::PH_NLEN;
                        end
                    end
                end else begin
                    st.field_acc = acc_new;
                    st.field_pos = pos + 2'd1;
                end
            end
            scp_pkg::PH_NLEN: begin
                result.role          = scp_pkg::ROLE_NLEN;
                result.section_index = cur_state.current_section;
                if (pos != 2'd0) begin
                    result.field_end = 1'b1;
                    st.field_pos = 2'd0;
                    st.field_acc = 32'd0;
                    if (acc_new[15:0] == 16'd0) begin
                        st.phase = scp_pkg::PH_DLEN;
                    end else begin
                        st.payload_left = {16'd0, acc_new[15:0]};
                        st.phase        = scp_pkg::PH_NAME;
                    end
                end else begin
                    st.field_acc = acc_new;
                    st.field_pos = pos + 2'd1;
                end
            end
            scp_pkg::PH_NAME: begin
                result.role          = scp_pkg::ROLE_NAME;
                result.section_index = cur_state.current_section;
                st.payload_left = payload_dec;
                if (payload_dec == 32'd0) begin
                    result.field_end = 1'b1;
                    st.phase     = scp_pkg::PH_DLEN;
                    st.field_pos = 2'd0;
                    st.field_acc = 32'd0;
                end
            end
            scp_pkg::PH_DLEN: begin
                result.role          = scp_pkg::ROLE_DLEN;
                result.section_index = cur_state.current_section;
                if (pos == 2'd3) begin
                    result.field_end = 1'b1;
                    st.field_pos = 2'd0;
                    st.field_acc = 32'd0;
                    if (acc_new == 32'd0) begin
                        st.current_section = sec_inc;
                        st.sections_left   = left_dec;
                        if (left_dec == 32'd0) begin
                            st.parse_status = scp_pkg::ST_DONE;
                            st.phase        = scp_pkg::PH_IDLE;
                        end else begin
                            st.phase = scp_pkg::PH_NLEN;
                        end
                    end else begin
                        st.payload_left = acc_new;
                        st.phase        = scp_pkg::PH_DATA;
                    end
                end else begin
                    st.field_acc = acc_new;
                    st.field_pos = pos + 2'd1;
                end
            end
            scp_pkg::PH_DATA: begin
                result.role          = scp_pkg::ROLE_DATA;
                result.section_index = cur_state.current_section;
                st.payload_left = payload_dec;
                if (payload_dec == 32'd0) begin
                    result.field_end   = 1'b1;
                    st.field_pos       = 2'd0;
                    st.field_acc       = 32'd0;
                    st.current_section = sec_inc;
                    st.sections_left   = left_dec;
                    if (left_dec == 32'd0) begin
                        st.parse_status = scp_pkg::ST_DONE;
                        st.phase        = scp_pkg::PH_IDLE;
                    end else begin
                        st.phase = scp_pkg::PH_NLEN;
                    end
                end
            end
            default: begin
                result.role = scp_pkg::ROLE_IGNORED;
            end
        endcase

        result.status = st.parse_status;
        if (end_of_buffer) begin
            if (st.parse_status == scp_pkg::ST_BUSY) begin
                result.status = scp_pkg::ST_REJECTED;
            end
            st = scp_pkg::STATE_RESET;
        end
        nxt_state = st;
    end

endmodule

// File: hw/rtl/section_container_parser_unit.sv
// top level of the section container parser: input stage, parse state, result stage
//
//  channel  dir  handshake              payload
//  s_       in   s_tvalid / s_tready    s_tdata byte_value, s_tlast end_of_buffer
//  m_       out  m_tvalid / m_tready    m_tdata byte_echo, section_index;
//                                       m_tuser role, status; m_tlast field_end
//  cfg_     in   cfg_valid / cfg_ready  cfg_index, cfg_data (0 magic, 1 version)
//
//  one byte per cycle sustained while m_tready is high; input register, then result register
//  the parse state update is a combinational step between input and result registers
//  aresetn clears state, both stages and reloads the default magic and version
//  a stalled m_tready holds the result; the input stage fills, then s_tready drops
//  cfg_ready is always high
module section_container_parser_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_value
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] byte_echo, [39:8] section_index
    output logic [4:0]  m_tuser,   // [2:0] role, [4:3] status
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic                 in_valid_reg;
    logic [7:0]           in_byte_reg;
    logic                 in_eob_reg;
    logic                 out_valid_reg;
    scp_pkg::scp_result_t out_reg;
    scp_pkg::scp_state_t  state_reg;
    scp_pkg::scp_state_t  state_next;
    scp_pkg::scp_result_t step_result;
    logic [31:0]          magic_word_reg;
    logic [31:0]          expected_version_reg;
    logic                 advance;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    scp_step u_step (
        .cur_state        (state_reg),
        .byte_value       (in_byte_reg),
        .end_of_buffer    (in_eob_reg),
        .magic_word       (magic_word_reg),
        .expected_version (expected_version_reg),
        .nxt_state        (state_next),
        .result           (step_result)
    );

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            magic_word_reg       <= scp_pkg::MAGIC_RESET;
            expected_version_reg <= scp_pkg::VERSION_RESET;
        end else if (cfg_valid && cfg_index[7:1] == 7'd0) begin
            if (cfg_index[0] == scp_pkg::CFG_IDX_MAGIC) begin
                magic_word_reg <= cfg_data;
            end
            if (cfg_index[0] == scp_pkg::CFG_IDX_VERSION) begin
                expected_version_reg <= cfg_data;
            end
        end
    end

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_eob_reg  <= s_tlast;
        end
    end

    // parse state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= scp_pkg::STATE_RESET;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.section_index, out_reg.byte_echo};
    assign m_tuser  = {out_reg.status, out_reg.role};
    assign m_tlast  = out_reg.field_end;

    a_eob_rearms: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_eob_reg |=> state_reg.phase == scp_pkg::PH_MAGIC
            && state_reg.parse_status == scp_pkg::ST_BUSY)
        else $error("end of buffer did not re-arm the header search");

    a_ignored_no_end: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.role == scp_pkg::ROLE_IGNORED |-> !out_reg.field_end)
        else $error("ignored byte marked as field end");

    a_header_index: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.role == scp_pkg::ROLE_HEADER
            |-> out_reg.section_index == 32'd0)
        else $error("header byte carries a section index");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_tready |-> !advance)
        else $error("result overwritten while stalled");

    a_idle_settled: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.phase == scp_pkg::PH_IDLE |-> state_reg.parse_status != scp_pkg::ST_BUSY)
        else $error("idle phase with parse still in progress");

endmodule

// File: tb/tb_section_container_parser_unit.sv
// self-checking testbench for section_container_parser_unit: byte-stream containers
module tb_section_container_parser_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 300000;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } buffer_byte_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'd0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;
    logic [4:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = 8'd0;
    logic [31:0] cfg_data  = 32'd0;

    section_container_parser_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    buffer_byte_t          byte_stream[$];
    scp_pkg::scp_result_t  expected_tags[$];
    logic [7:0]            frame[$];

    int  mismatches = 0;
    int  cycles     = 0;
    bit  s_taken    = 1'b0;
    bit  no_idle    = 1'b0;
    bit  src_quiet  = 1'b0;
    bit  sink_quiet = 1'b0;
    int  src_gap    = 0;
    int  sink_gap   = 0;

    // parser model state and register copies
    logic [31:0]      cfg_magic;
    logic [31:0]      cfg_version;
    scp_pkg::phase_t  ph;
    logic [1:0]       fpos;
    logic [31:0]      facc;
    logic [31:0]      sec_left;
    logic [31:0]      cur_sec;
    logic [31:0]      pay_left;
    scp_pkg::status_t pstat;

    function automatic void clear_parse();
        ph       = scp_pkg::PH_MAGIC;
        fpos     = 2'd0;
        facc     = 32'd0;
        sec_left = 32'd0;
        cur_sec  = 32'd0;
        pay_left = 32'd0;
        pstat    = scp_pkg::ST_BUSY;
    endfunction

    function automatic void enter_phase(input scp_pkg::phase_t p);
        ph   = p;
        fpos = 2'd0;
        facc = 32'd0;
    endfunction

    function automatic void reject_buffer();
        pstat = scp_pkg::ST_REJECTED;
        enter_phase(scp_pkg::PH_IDLE);
    endfunction

    function automatic void close_section();
        cur_sec  = cur_sec + 32'd1;
        sec_left = sec_left - 32'd1;
        if (sec_left == 32'd0) begin
            pstat = scp_pkg::ST_DONE;
            enter_phase(scp_pkg::PH_IDLE);
        end else begin
            enter_phase(scp_pkg::PH_NLEN);
        end
    endfunction

    function automatic bit take_byte(input logic [7:0] b, input int width);
        int pos;
        pos  = int'(fpos);
        facc = facc | (32'(b) << (8 * pos));
        if (pos + 1 >= width) begin
            fpos = 2'd0;
            return 1'b1;
        end
        fpos = 2'(pos + 1);
        return 1'b0;
    endfunction

    function automatic scp_pkg::scp_result_t tag_byte(input logic [7:0] b, input logic eob);
        scp_pkg::scp_result_t r;
        logic [31:0] v;
        r.byte_echo     = b;
        r.role          = scp_pkg::ROLE_IGNORED;
        r.section_index = 32'd0;
        r.field_end     = 1'b0;
        case (ph)
            scp_pkg::PH_MAGIC, scp_pkg::PH_VERSION, scp_pkg::PH_COUNT: begin
                r.role = scp_pkg::ROLE_HEADER;
                if (take_byte(b, 4)) begin
                    r.field_end = 1'b1;
                    v = facc;
                    if (ph == scp_pkg::PH_MAGIC) begin
                        if (v != cfg_magic) reject_buffer();
                        else enter_phase(scp_pkg::PH_VERSION);
                    end else if (ph == scp_pkg::PH_VERSION) begin
                        if (v != cfg_version) reject_buffer();
                        else enter_phase(scp_pkg::PH_COUNT);
                    end else begin
                        sec_left = v;
                        cur_sec  = 32'd0;
                        if (v == 32'd0) begin
                            pstat = scp_pkg::ST_DONE;
                            enter_phase(scp_pkg::PH_IDLE);
                        end else begin
                            enter_phase(scp_pkg::PH_NLEN);
                        end
                    end
                end
            end
            scp_pkg::PH_NLEN: begin
                r.role          = scp_pkg::ROLE_NLEN;
                r.section_index = cur_sec;
                if (take_byte(b, 2)) begin
                    r.field_end = 1'b1;
                    v = {16'd0, facc[15:0]};
                    if (v == 32'd0) begin
                        enter_phase(scp_pkg::PH_DLEN);
                    end else begin
                        pay_left = v;
                        enter_phase(scp_pkg::PH_NAME);
                    end
                end
            end
            scp_pkg::PH_NAME: begin
                r.role          = scp_pkg::ROLE_NAME;
                r.section_index = cur_sec;
                pay_left        = pay_left - 32'd1;
                if (pay_left == 32'd0) begin
                    r.field_end = 1'b1;
                    enter_phase(scp_pkg::PH_DLEN);
                end
            end
            scp_pkg::PH_DLEN: begin
                r.role          = scp_pkg::ROLE_DLEN;
                r.section_index = cur_sec;
                if (take_byte(b, 4)) begin
                    r.field_end = 1'b1;
                    v = facc;
                    if (v == 32'd0) begin
                        close_section();
                    end else begin
                        pay_left = v;
                        enter_phase(scp_pkg::PH_DATA);
                    end
                end
            end
            scp_pkg::PH_DATA: begin
                r.role          = scp_pkg::ROLE_DATA;
                r.section_index = cur_sec;
                pay_left        = pay_left - 32'd1;
                if (pay_left == 32'd0) begin
                    r.field_end = 1'b1;
                    close_section();
                end
            end
            default: begin
            end
        endcase
        r.status = pstat;
        if (eob) begin
            if (r.status == scp_pkg::ST_BUSY) r.status = scp_pkg::ST_REJECTED;
            clear_parse();
        end
        return r;
    endfunction

    // transaction capture and result checking
    always @(posedge aclk) begin
        scp_pkg::scp_result_t want;
        cycles  = cycles + 1;
        s_taken = aresetn && s_tvalid && s_tready;
        if (s_taken) expected_tags.insert(expected_tags.size(), tag_byte(s_tdata, s_tlast));
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_tags.size() == 0) begin
                $error("unexpected result: byte_echo %0d", m_tdata[7:0]);
                mismatches++;
            end else begin
                want = expected_tags.pop_front();
                if (m_tdata[7:0] !== want.byte_echo) begin
                    $error("byte_echo: expected %0d, actual %0d",
                           want.byte_echo, m_tdata[7:0]);
                    mismatches++;
                end
                if (m_tuser[2:0] !== want.role) begin
                    $error("role: expected %0d, actual %0d", want.role, m_tuser[2:0]);
                    mismatches++;
                end
                if (m_tdata[39:8] !== want.section_index) begin
                    $error("section_index: expected %0d, actual %0d",
                           want.section_index, m_tdata[39:8]);
                    mismatches++;
                end
                if (m_tlast !== want.field_end) begin
                    $error("field_end: expected %0d, actual %0d", want.field_end, m_tlast);
                    mismatches++;
                end
                if (m_tuser[4:3] !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, m_tuser[4:3]);
                    mismatches++;
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("section_container_parser_unit: mismatch");
            $finish;
        end
    end

    // byte driver
    always @(negedge aclk) begin
        buffer_byte_t item;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_taken) begin
            if (src_gap > 0) begin
                src_gap = src_gap - 1;
                s_tvalid <= 1'b0;
            end else if (byte_stream.size() > 0) begin
                item = byte_stream.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= item.value;
                s_tlast  <= item.last;
                if ($urandom_range(0, 63) == 0) src_quiet = ~src_quiet;
                if (!no_idle && !src_quiet && $urandom_range(0, 9) == 0)
                    src_gap = $urandom_range(1, 15);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result sink with back-pressure bursts
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap = sink_gap - 1;
            m_tready <= 1'b0;
        end else if (!no_idle && !sink_quiet && $urandom_range(0, 11) == 0) begin
            sink_gap = $urandom_range(1, 15) - 1;
            m_tready <= 1'b0;
        end else begin
            if ($urandom_range(0, 63) == 0) sink_quiet = ~sink_quiet;
            m_tready <= 1'b1;
        end
    end

    task automatic put_word(input logic [31:0] w, input int n);
        for (int i = 0; i < n; i++) frame.insert(frame.size(), w[8*i +: 8]);
    endtask

    task automatic put_junk(input int n);
        for (int i = 0; i < n; i++) frame.insert(frame.size(), 8'($urandom_range(0, 255)));
    endtask

    task automatic send_frame(input int keep);
        buffer_byte_t entry;
        for (int i = 0; i < keep; i++) begin
            entry.value = frame[i];
            entry.last  = (i == keep - 1);
            byte_stream.insert(byte_stream.size(), entry);
        end
        frame.delete();
    endtask

    task automatic put_section(input bit huge_data);
        int nlen;
        int dlen;
        nlen = ($urandom_range(0, 29) == 0) ? $urandom_range(256, 260) : $urandom_range(0, 4);
        put_word(32'(nlen), 2);
        put_junk(nlen);
        if (huge_data) begin
            put_word($urandom | 32'h100, 4);
            put_junk($urandom_range(0, 4));
        end else begin
            dlen = $urandom_range(0, 6);
            put_word(32'(dlen), 4);
            put_junk(dlen);
        end
    endtask

    task automatic add_buffer();
        int kind;
        int count;
        logic [31:0] declared;
        kind = $urandom_range(0, 9);
        if (kind <= 5) begin
            count = $urandom_range(0, 3);
            put_word(cfg_magic, 4);
            put_word(cfg_version, 4);
            put_word(32'(count), 4);
            for (int i = 0; i < count; i++) put_section(1'b0);
            put_junk($urandom_range(0, 2));
            send_frame(frame.size());
        end else if (kind == 6) begin
            put_word(cfg_magic ^ (32'd1 << $urandom_range(0, 31)), 4);
            put_junk($urandom_range(0, 3));
            send_frame(frame.size());
        end else if (kind == 7) begin
            put_word(cfg_magic, 4);
            put_word(cfg_version ^ (32'd1 << $urandom_range(0, 31)), 4);
            put_junk($urandom_range(0, 3));
            send_frame(frame.size());
        end else if (kind == 8) begin
            declared = $urandom_range(0, 1) ? 32'($urandom_range(1, 3)) : ($urandom | 32'd1);
            put_word(cfg_magic, 4);
            put_word(cfg_version, 4);
            put_word(declared, 4);
            for (int i = 0; i < 2 && i < declared; i++) put_section($urandom_range(0, 1));
            send_frame($urandom_range(1, frame.size()));
        end else begin
            put_junk($urandom_range(1, 8));
            send_frame(frame.size());
        end
    endtask

    task automatic fill_random(input int n);
        while (byte_stream.size() < n) add_buffer();
    endtask

    task automatic wait_drained();
        do @(posedge aclk);
        while (byte_stream.size() > 0 || s_tvalid || expected_tags.size() > 0);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [31:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk);
        while (!cfg_ready);
        if (idx == 8'(scp_pkg::CFG_IDX_MAGIC)) cfg_magic = value;
        else if (idx == 8'(scp_pkg::CFG_IDX_VERSION)) cfg_version = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        cfg_magic   = scp_pkg::MAGIC_RESET;
        cfg_version = scp_pkg::VERSION_RESET;
        clear_parse();
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // one section with empty name and data, then a trailing byte
        put_word(cfg_magic, 4);
        put_word(cfg_version, 4);
        put_word(32'd1, 4);
        put_word(32'd0, 2);
        put_word(32'd0, 4);
        put_word(32'hFF, 1);
        send_frame(frame.size());
        // wrong magic, then a byte in the rejected state
        put_word(32'h0000_FF00, 4);
        put_word(32'h5A, 1);
        send_frame(frame.size());
        // buffer ending on its first byte
        put_word(32'h4B, 1);
        send_frame(1);
        wait_drained();

        fill_random(120);
        wait_drained();

        write_reg(8'(scp_pkg::CFG_IDX_MAGIC), 32'h0000_0000);
        write_reg(8'(scp_pkg::CFG_IDX_VERSION), 32'h0000_0000);
        fill_random(120);
        wait_drained();

        write_reg(8'(scp_pkg::CFG_IDX_MAGIC), 32'hFFFF_FFFF);
        write_reg(8'(scp_pkg::CFG_IDX_VERSION), 32'hFFFF_FFFF);
        fill_random(120);
        wait_drained();

        write_reg(8'(scp_pkg::CFG_IDX_MAGIC), $urandom);
        write_reg(8'(scp_pkg::CFG_IDX_VERSION), $urandom);
        no_idle = 1'b1;
        fill_random(140);
        wait_drained();

        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("section_container_parser_unit: match");
        end else begin
            $display("section_container_parser_unit: mismatch");
        end
        $finish;
    end

endmodule
